// File: sv/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

	// conversion modes
	localparam logic [2:0] OP_SDEC  = 3'd0;
	localparam logic [2:0] OP_UDEC  = 3'd1;
	localparam logic [2:0] OP_HEX64 = 3'd2;
	localparam logic [2:0] OP_HEXU  = 3'd3;
	localparam logic [2:0] OP_RADIX = 3'd4;

	// fixed radixes and clamp limits
	localparam logic [4:0] RADIX_DEC = 5'd10;
	localparam logic [4:0] RADIX_HEX = 5'd16;
	localparam logic [4:0] RADIX_MIN = 5'd2;
	localparam logic [4:0] RADIX_MAX = 5'd16;

	// characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_UP_A  = 8'h41;

	// divider geometry: dividend bits consumed per cycle
	localparam int WIDE_W    = 64;
	localparam int NARROW_W  = 32;
	localparam int DIV_STEPS = 8;
	localparam int PASS_W    = $clog2(WIDE_W / DIV_STEPS);

	// digit stack: longest digit string is 32 bits in base 2
	localparam int DIG_DEPTH = 32;
	localparam int DIG_IW    = $clog2(DIG_DEPTH);
	localparam int DIG_CW    = $clog2(DIG_DEPTH + 1);

	typedef struct packed {
		logic       start;
		logic       wide;
		logic [4:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// digit value to ascii, lower or upper case letters
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UP_A : CH_LOW_A;
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {4'd0, d};
		end else begin
			digit_char = base + {4'd0, d - 4'd10};
		end
	endfunction

endpackage

`default_nettype wire

// File: sv/itoa_divider.sv
`default_nettype none

// shared long divider by a small divisor (2..16), several quotient bits a cycle
module itoa_divider (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire itoa_pkg::div_req_t   req,
	input  wire logic [63:0]          dividend,
	output itoa_pkg::div_stat_t       stat,
	output logic [63:0]               quotient,
	output logic [3:0]                remainder
);

	localparam logic [itoa_pkg::PASS_W-1:0] LAST_WIDE =
		itoa_pkg::PASS_W'(itoa_pkg::WIDE_W / itoa_pkg::DIV_STEPS - 1);
	localparam logic [itoa_pkg::PASS_W-1:0] LAST_NARROW =
		itoa_pkg::PASS_W'(itoa_pkg::NARROW_W / itoa_pkg::DIV_STEPS - 1);

	logic [63:0]                  w_q;
	logic [3:0]                   rem_q;
	logic [4:0]                   div_q;
	logic                         wide_q;
	logic [itoa_pkg::PASS_W-1:0]  cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [63:0] w_n;
	logic [3:0]  rem_n;

	// restoring steps: shift a dividend bit into the remainder, subtract if it fits
	always_comb begin
		logic [4:0] t;
		logic       ge;
		w_n   = w_q;
		rem_n = rem_q;
		for (int i = 0; i < itoa_pkg::DIV_STEPS; i++) begin
			t     = {rem_n, w_n[63]};
			ge    = (t >= div_q);
			t     = ge ? (t - div_q) : t;
			rem_n = t[3:0];
			w_n   = {w_n[62:0], ge};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == (wide_q ? LAST_WIDE : LAST_NARROW)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			w_q    <= req.wide ? dividend : {dividend[31:0], 32'd0};
			rem_q  <= 4'd0;
			div_q  <= req.divisor;
			wide_q <= req.wide;
		end else if (busy_q) begin
			w_q   <= w_n;
			rem_q <= rem_n;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = wide_q ? w_q : {32'd0, w_q[31:0]};
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: sv/integer_to_ascii_radix.sv
`default_nettype none

// channel  signals                      fields
// input    in_valid / in_stall          op, value, radix
// output   out_valid / out_stall        ch, count, last
//
// each digit is one division in the shared divider, which resolves 8
// quotient bits per cycle over 32 dividend bits (all 64 for 64-bit hex);
// digits are stacked, then sent one character a cycle while the output is
// not stalled, and the next word may enter in the cycle after the last
// character is loaded.
// in_stall stays high from the accepted word until its last character is loaded.
// an undefined mode is accepted and gives no characters.
// a stalled output holds its character; while the last one is held, the next word may enter.
// reset clears the sequencer and the output valid; no memory clearing is needed.
module integer_to_ascii_radix #(
	parameter int MAX_CHARS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [63:0] value,
	input  wire logic [4:0]  radix,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       ch,
	output logic [5:0]       count,
	output logic             last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [6:0] MAX_LIM = 7'(MAX_CHARS);

	logic [1:0]                  state_q;
	logic                        kick_q;
	logic [63:0]                 mag_q;
	logic                        wide_q;
	logic                        upper_q;
	logic                        neg_q;
	logic                        neg_pend_q;
	logic [4:0]                  divisor_q;
	logic [itoa_pkg::DIG_CW-1:0] nd_q;
	logic [itoa_pkg::DIG_IW-1:0] rd_ptr_q;
	logic [6:0]                  emit_cnt_q;
	logic [6:0]                  limit_q;
	logic [3:0]                  dig_q [itoa_pkg::DIG_DEPTH];

	logic                        out_valid_q;
	logic [7:0]                  ch_q;
	logic [5:0]                  count_q;
	logic                        last_q;

	itoa_pkg::div_req_t  req;
	itoa_pkg::div_stat_t stat;
	logic [63:0]         quot;
	logic [3:0]          rem;
	logic [63:0]         dividend;

	logic        accept;
	logic        op_ok;
	logic        neg_in;
	logic [31:0] low;
	logic [4:0]  radix_cl;
	logic        div_done;
	logic        quot_zero;
	logic [6:0]  len;
	logic        emit_go;
	logic [6:0]  emit_cnt_n;
	logic        emit_last;
	logic [7:0]  ch_n;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign op_ok    = (op <= itoa_pkg::OP_RADIX);
	assign low      = value[31:0];
	assign neg_in   = (op == itoa_pkg::OP_SDEC) && low[31];

	// clamp the free radix into its legal range
	always_comb begin
		if (radix < itoa_pkg::RADIX_MIN) begin
			radix_cl = itoa_pkg::RADIX_MIN;
		end else if (radix > itoa_pkg::RADIX_MAX) begin
			radix_cl = itoa_pkg::RADIX_MAX;
		end else begin
			radix_cl = radix;
		end
	end

	// divider requests: first digit from the loaded magnitude, then back to back
	assign div_done    = (state_q == ST_DIV) && stat.done;
	assign quot_zero   = (quot == 64'd0);
	assign req.start   = kick_q || (div_done && !quot_zero);
	assign req.wide    = wide_q;
	assign req.divisor = divisor_q;
	assign dividend    = kick_q ? mag_q : quot;

	itoa_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.dividend  (dividend),
		.stat      (stat),
		.quotient  (quot),
		.remainder (rem)
	);

	// text length, minus sign included, before the cut to the character limit
	assign len = 7'(neg_q) + 7'(nd_q) + 7'd1;

	// character emission into the output register
	assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_cnt_n = emit_cnt_q + 7'd1;
	assign emit_last  = (emit_cnt_n == limit_q);
	assign ch_n       = neg_pend_q ? itoa_pkg::CH_MINUS
	                               : itoa_pkg::digit_char(dig_q[rd_ptr_q], upper_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kick_q  <= 1'b0;
		end else begin
			kick_q <= accept && op_ok;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op_ok) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done && quot_zero) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go && emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item setup, digit stack and read pointer
	always_ff @(posedge clk) begin
		if (accept) begin
			wide_q     <= (op == itoa_pkg::OP_HEX64);
			upper_q    <= (op == itoa_pkg::OP_HEXU);
			neg_q      <= neg_in;
			neg_pend_q <= neg_in;
			nd_q       <= '0;
			emit_cnt_q <= '0;
			if (op == itoa_pkg::OP_HEX64) begin
				mag_q <= value;
			end else if (neg_in) begin
				mag_q <= {32'd0, 32'd0 - low};
			end else begin
				mag_q <= {32'd0, low};
			end
			case (op) inside
				itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC: divisor_q <= itoa_pkg::RADIX_DEC;
				itoa_pkg::OP_HEX64, itoa_pkg::OP_HEXU: divisor_q <= itoa_pkg::RADIX_HEX;
				default: divisor_q <= radix_cl;
			endcase
		end
		if (div_done) begin
			dig_q[nd_q[itoa_pkg::DIG_IW-1:0]] <= rem;
			nd_q <= nd_q + 1'b1;
			if (quot_zero) begin
				rd_ptr_q <= nd_q[itoa_pkg::DIG_IW-1:0];
				limit_q  <= (len > MAX_LIM) ? MAX_LIM : len;
			end
		end
		if (emit_go) begin
			emit_cnt_q <= emit_cnt_n;
			if (neg_pend_q) begin
				neg_pend_q <= 1'b0;
			end else begin
				rd_ptr_q <= rd_ptr_q - 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			ch_q    <= ch_n;
			count_q <= emit_cnt_n[5:0];
			last_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign ch        = ch_q;
	assign count     = count_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// File: sv/itoa_checker.sv
`default_nettype none

// port level checks on the converter
module itoa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  op,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  ch,
	input wire logic [5:0]  count,
	input wire logic        last
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ch) && $stable(count) && $stable(last))
		else $error("stalled output word changed");

	// a word in a defined mode makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op <= itoa_pkg::OP_RADIX) |=> in_stall)
		else $error("input not stalled after accepted word");

	// characters still pending keep the input stalled
	a_pending_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open before last character");

	// a character always carries a nonzero count, and a minus sign is never last
	a_count_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count != 6'd0) && !(last && (ch == itoa_pkg::CH_MINUS)))
		else $error("bad count or lone minus sign");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);

`default_nettype wire

// File: dv/integer_to_ascii_radix_tb.sv
`default_nettype none

module integer_to_ascii_radix_tb;

	localparam int TEXT_MAX    = 32;
	localparam int RAND_WORDS  = 80;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 400;
	localparam int SHOW_ERRORS = 10;

	// one character word as it leaves the block
	typedef struct packed {
		logic [7:0] ch;
		logic [5:0] count;
		logic       last;
	} char_word_t;

	// one conversion request, with typed-in text where it is obvious
	typedef struct {
		logic [2:0]  op;
		logic [63:0] value;
		logic [4:0]  radix;
		bit          typed;
		string       text;
	} conv_word_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = itoa_pkg::OP_SDEC;
	logic [63:0] value = 64'd0;
	logic [4:0]  radix = itoa_pkg::RADIX_MIN;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  ch;
	logic [5:0]  count;
	logic        last;

	char_word_t  pending_chars[$];
	conv_word_t  directed_rows[$];
	int          err_cnt = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	integer_to_ascii_radix DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.radix     (radix),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ch        (ch),
		.count     (count),
		.last      (last)
	);

	always #5 clk = ~clk;

	// expected characters of one conversion, most significant first
	function automatic void predict_chars(input logic [2:0] op_i, input logic [63:0] value_i,
			input logic [4:0] radix_i);
		string       lower_set;
		string       upper_set;
		logic [7:0]  rev[$];
		logic [7:0]  txt[$];
		logic [31:0] low;
		logic [63:0] mag;
		logic [4:0]  base5;
		logic [63:0] base;
		logic [3:0]  dig;
		bit          upper;
		int          n;
		int          k;
		lower_set = "0123456789abcdef";
		upper_set = "0123456789ABCDEF";
		low = value_i[31:0];
		upper = 1'b0;
		base5 = itoa_pkg::RADIX_DEC;
		case (op_i)
			itoa_pkg::OP_SDEC: begin
				mag = {32'd0, low};
				// magnitude in unsigned 32-bit so the most negative int survives
				if (low[31]) begin
					txt.push_back(itoa_pkg::CH_MINUS);
					mag = {32'd0, 32'd0 - low};
				end
			end
			itoa_pkg::OP_UDEC: mag = {32'd0, low};
			itoa_pkg::OP_HEX64: begin
				mag = value_i;
				base5 = itoa_pkg::RADIX_HEX;
			end
			itoa_pkg::OP_HEXU: begin
				mag = {32'd0, low};
				base5 = itoa_pkg::RADIX_HEX;
				upper = 1'b1;
			end
			itoa_pkg::OP_RADIX: begin
				mag = {32'd0, low};
				// clamp the base into 2..16
				if (radix_i < itoa_pkg::RADIX_MIN) begin
					base5 = itoa_pkg::RADIX_MIN;
				end else if (radix_i > itoa_pkg::RADIX_MAX) begin
					base5 = itoa_pkg::RADIX_MAX;
				end else begin
					base5 = radix_i;
				end
			end
			default: return;
		endcase
		base = {59'd0, base5};
		// digits come out least significant first
		do begin
			dig = 4'(mag % base);
			rev.push_back(upper ? upper_set[dig] : lower_set[dig]);
			mag = mag / base;
		end while (mag != 64'd0);
		while (rev.size() > 0) txt.push_back(rev.pop_back());
		n = (txt.size() > TEXT_MAX) ? TEXT_MAX : txt.size();
		for (k = 0; k < n; k++) begin
			pending_chars.push_back('{ch: txt[k], count: 6'(k + 1), last: (k == n - 1)});
		end
	endfunction

	// expected characters straight from a typed-in string
	function automatic void push_typed(input string s);
		int k;
		for (k = 0; k < s.len(); k++) begin
			pending_chars.push_back('{ch: s[k], count: 6'(k + 1), last: (k == s.len() - 1)});
		end
	endfunction

	function automatic void add_row(input logic [2:0] op_i, input logic [63:0] value_i,
			input logic [4:0] radix_i, input bit typed_i, input string text_i);
		conv_word_t w;
		w.op = op_i;
		w.value = value_i;
		w.radix = radix_i;
		w.typed = typed_i;
		w.text = text_i;
		directed_rows.push_back(w);
	endfunction

	function automatic void report_mismatch(input string what, input char_word_t want,
			input char_word_t got);
		err_cnt++;
		if (err_cnt <= SHOW_ERRORS) begin
			$display("mismatch (%s): expected ch=%h count=%0d last=%0b, got ch=%h count=%0d last=%0b",
				what, want.ch, want.count, want.last, got.ch, got.count, got.last);
		end
	endfunction

	// drive one word in bursts, push its characters once accepted
	task automatic send_word(input conv_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		op = w.op;
		value = w.value;
		radix = w.radix;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (w.typed) begin
			push_typed(w.text);
		end else begin
			predict_chars(w.op, w.value, w.radix);
		end
		@(negedge clk);
	endtask

	// receiver stall pattern, with a new random mode whenever stall_left runs out
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= ((stall_left % 16) < 6);
		endcase
	end

	// compare each accepted character with the oldest expectation, plus watchdog
	always @(posedge clk) begin : out_check
		char_word_t got;
		char_word_t want;
		if (out_valid && !out_stall) begin
			got = '{ch: ch, count: count, last: last};
			if (pending_chars.size() == 0) begin
				report_mismatch("unexpected word", '0, got);
			end else begin
				want = pending_chars.pop_front();
				if (got != want) report_mismatch("wrong field", want, got);
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		conv_word_t w;
		int         rand_cnt;
		logic [31:0] hi;
		logic [31:0] lo;

		// directed rows: extremes, every mode, clamping and undefined modes
		add_row(itoa_pkg::OP_SDEC, 64'd0, itoa_pkg::RADIX_MIN, 1, "0");
		add_row(itoa_pkg::OP_SDEC, 64'h0000_0000_8000_0000, itoa_pkg::RADIX_MIN, 1,
			"-2147483648");
		add_row(itoa_pkg::OP_SDEC, 64'h0000_0000_7fff_ffff, itoa_pkg::RADIX_MIN, 1,
			"2147483647");
		add_row(itoa_pkg::OP_SDEC, 64'hffff_ffff_ffff_ffff, 5'd31, 1, "-1");
		add_row(itoa_pkg::OP_SDEC, 64'hdead_beef_0000_007b, itoa_pkg::RADIX_HEX, 1, "123");
		add_row(itoa_pkg::OP_UDEC, 64'h0000_0000_ffff_ffff, itoa_pkg::RADIX_MIN, 1,
			"4294967295");
		add_row(itoa_pkg::OP_UDEC, 64'hffff_ffff_0000_0000, 5'd0, 1, "0");
		add_row(itoa_pkg::OP_UDEC, 64'h0000_0000_8000_0000, 5'd31, 1, "2147483648");
		add_row(itoa_pkg::OP_HEX64, 64'hffff_ffff_ffff_ffff, 5'd31, 1, "ffffffffffffffff");
		add_row(itoa_pkg::OP_HEX64, 64'd0, itoa_pkg::RADIX_MIN, 1, "0");
		add_row(itoa_pkg::OP_HEX64, 64'h0123_4567_89ab_cdef, itoa_pkg::RADIX_DEC, 1,
			"123456789abcdef");
		add_row(itoa_pkg::OP_HEXU, 64'hffff_ffff_ffff_ffff, 5'd0, 1, "FFFFFFFF");
		add_row(itoa_pkg::OP_HEXU, 64'h1234_5678_cafe_f00d, itoa_pkg::RADIX_DEC, 1,
			"CAFEF00D");
		add_row(itoa_pkg::OP_RADIX, 64'h0000_0000_ffff_ffff, itoa_pkg::RADIX_MIN, 0, "");
		add_row(itoa_pkg::OP_RADIX, 64'h0000_0000_8000_0000, itoa_pkg::RADIX_MIN, 0, "");
		add_row(itoa_pkg::OP_RADIX, 64'hffff_ffff_0000_0000, itoa_pkg::RADIX_HEX, 1, "0");
		add_row(itoa_pkg::OP_RADIX, 64'd255, 5'd0, 1, "11111111");
		add_row(itoa_pkg::OP_RADIX, 64'd255, 5'd1, 1, "11111111");
		add_row(itoa_pkg::OP_RADIX, 64'd255, 5'd17, 1, "ff");
		add_row(itoa_pkg::OP_RADIX, 64'd255, 5'd31, 1, "ff");
		add_row(itoa_pkg::OP_RADIX, 64'd12345, 5'd7, 0, "");
		add_row(itoa_pkg::OP_RADIX, 64'h0000_0000_ffff_ffff, 5'd3, 0, "");
		add_row(3'd5, 64'h0000_0000_0000_0001, itoa_pkg::RADIX_DEC, 1, "");
		add_row(3'd6, 64'hffff_ffff_ffff_ffff, 5'd31, 1, "");
		add_row(3'd7, 64'h8000_0000_8000_0000, itoa_pkg::RADIX_MIN, 1, "");

		// reset once at the start
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) send_word(directed_rows[i]);

		// random words, mostly defined modes with a little undefined noise
		rand_cnt = 0;
		while (rand_cnt < RAND_WORDS) begin
			if ($urandom_range(0, 11) == 0) begin
				w.op = 3'($urandom_range(5, 7));
			end else begin
				w.op = 3'($urandom_range(0, 4));
			end
			if ($urandom_range(0, 7) == 0) begin
				w.radix = 5'($urandom);
			end else begin
				w.radix = 5'($urandom_range(2, 16));
			end
			hi = $urandom;
			lo = $urandom;
			case ($urandom_range(0, 3))
				0: lo = $urandom_range(0, 40);
				1: lo = $urandom_range(0, 1) ? 32'h8000_0000 - $urandom_range(0, 1)
					: 32'hffff_ffff - $urandom_range(0, 1);
				default: ;
			endcase
			if (w.op == itoa_pkg::OP_HEX64 && $urandom_range(0, 2) == 0) begin
				hi = $urandom_range(0, 15);
			end
			w.value = {hi, lo};
			w.typed = 1'b0;
			w.text = "";
			if (w.op <= itoa_pkg::OP_RADIX) rand_cnt++;
			send_word(w);
		end
		in_valid = 1'b0;

		// drain, then leave room for a late stray character
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_chars.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
